@@ rtl/sst_pkg.sv @@
`default_nettype none
package sst_pkg;

  localparam int SST_MAX_SLOTS = 16;

  // Command codes carried on in_tuser
  localparam logic [1:0] CMD_RECORD   = 2'd0;
  localparam logic [1:0] CMD_VALIDATE = 2'd1;
  localparam logic [1:0] CMD_RETIRE   = 2'd2;

  // Result status codes carried on out_tuser
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_INVALID   = 3'd1;
  localparam logic [2:0] STS_EXISTS    = 3'd2;
  localparam logic [2:0] STS_NOT_FOUND = 3'd3;
  localparam logic [2:0] STS_MISMATCH  = 3'd4;
  localparam logic [2:0] STS_FULL      = 3'd5;

  // First operation kind that is not accepted
  localparam logic [2:0] OP_LIMIT = 3'd4;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 72;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] gen;
    logic        retired;
    logic [1:0]  op;
    logic        comp;
    logic [31:0] len;
    logic [15:0] tag;
  } slot_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  idx;
    logic [15:0] gen;
    logic [1:0]  op;
    logic        comp;
    logic [31:0] len;
    logic [15:0] tag;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/sst_slot_ram.sv @@
`default_nettype none
module sst_slot_ram #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  wire                 clk,
  input  wire                 wr_en,
  input  wire [IDX_W-1:0]     wr_addr,
  input  sst_pkg::slot_t      wr_data,
  input  wire [IDX_W-1:0]     rd_addr,
  output sst_pkg::slot_t      rd_data
);
  import sst_pkg::*;

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ rtl/send_slot_shadow_tracker.sv @@
`default_nettype none
// Channel  Dir  Handshake             Payload
// in_      in   in_tvalid/in_tready   tuser: cmd; tdata: counter, generation, op, comp, len, tag
// out_     out  out_tvalid/out_tready tuser: status; tdata: index, generation, op, comp, len, tag
// cfg_     in   cfg_wr_en             cfg_wr_data: qp_live
//
// Search and sweep: retire adds a sweep of the used slots to the search that record
// and validate make. The key search and the sweep go through the single read port of
// the slot memory, one slot a cycle.
// Reset: synchronous, active low; clears the fill count and control, sets qp_live.
// Stalls: a result waits in the output register; the next item is taken while it
// waits, and its own result is held in the finish state until the register frees.
module send_slot_shadow_tracker #(
  parameter int MAX_SLOTS = sst_pkg::SST_MAX_SLOTS
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_tvalid,
  output logic                          in_tready,
  // [15:0] work counter, [31:16] generation, [34:32] op kind,
  // [35] completion flag, [67:36] byte length, [83:68] request tag
  input  wire [sst_pkg::IN_TDATA_W-1:0] in_tdata,
  // [1:0] cmd
  input  wire [1:0]                     in_tuser,
  output logic                          out_tvalid,
  input  wire                           out_tready,
  // [3:0] slot_index, [19:4] slot_generation, [21:20] slot_op,
  // [22] slot_completion, [54:23] slot_length, [70:55] slot_tag
  output logic [sst_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [2:0] status
  output logic [2:0]                    out_tuser,
  input  wire                           cfg_wr_en,
  input  wire                           cfg_wr_data
);
  import sst_pkg::*;

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SLOTS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_SWEEP  = 3'd2;
  localparam logic [2:0] ST_DONE   = 3'd3;

  // control
  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] scan_r, scan_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic             qp_live_r, qp_live_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  logic [IDX_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic [15:0]      key_r, key_nxt;
  logic [15:0]      gen_r, gen_nxt;
  logic [1:0]       op_r, op_nxt;
  logic             comp_r, comp_nxt;
  logic [31:0]      len_r, len_nxt;
  logic [15:0]      tag_r, tag_nxt;
  result_t          res_r, res_nxt;
  result_t          out_r, out_nxt;

  // memory port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  slot_t            mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  slot_t            mem_rdata;

  logic             issue;
  logic             hit;
  logic [15:0]      new_gen;
  logic [15:0]      key_diff;
  logic             sweep_hit;
  logic             accept;

  sst_slot_ram #(
    .DEPTH (MAX_SLOTS),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {1'b0, out_r.tag, out_r.len, out_r.comp, out_r.op, out_r.gen, out_r.idx};

  // rdata belongs to chk_idx_r when chk_v_r is set
  assign hit      = chk_v_r && (mem_rdata.key == key_r);
  assign new_gen  = (mem_rdata.gen == 16'hFFFF) ? 16'd1 : mem_rdata.gen + 16'd1;
  assign key_diff = mem_rdata.key - key_r;
  // retire an unretired slot of this generation at or before the counter
  assign sweep_hit = chk_v_r && !mem_rdata.retired && (mem_rdata.gen == gen_r) &&
                     ((key_diff == 16'd0) || key_diff[15]);

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    scan_nxt      = scan_r;
    chk_v_nxt     = 1'b0;
    chk_idx_nxt   = scan_r[IDX_W-1:0];
    qp_live_nxt   = cfg_wr_en ? cfg_wr_data : qp_live_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    gen_nxt       = gen_r;
    op_nxt        = op_r;
    comp_nxt      = comp_r;
    len_nxt       = len_r;
    tag_nxt       = tag_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    issue         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = chk_idx_r;
    mem_wdata     = mem_rdata;
    mem_raddr     = scan_r[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt  = in_tuser;
          key_nxt  = in_tdata[15:0];
          gen_nxt  = in_tdata[31:16];
          op_nxt   = in_tdata[33:32];
          comp_nxt = in_tdata[35];
          len_nxt  = in_tdata[67:36];
          tag_nxt  = in_tdata[83:68];
          scan_nxt = '0;
          res_nxt  = '0;
          if ((in_tuser != CMD_RECORD && in_tuser != CMD_VALIDATE &&
               in_tuser != CMD_RETIRE) ||
              (in_tuser == CMD_RECORD && (!qp_live_r || in_tdata[34:32] >= OP_LIMIT))) begin
            res_nxt.status = STS_INVALID;
            state_nxt      = ST_DONE;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        res_nxt = '0;
        if (hit) begin
          // stop on the matching slot
          if (cmd_r == CMD_RECORD) begin
            if (!mem_rdata.retired) begin
              res_nxt.status = STS_EXISTS;
            end else begin
              mem_we            = 1'b1;
              mem_waddr         = chk_idx_r;
              mem_wdata.key     = key_r;
              mem_wdata.gen     = new_gen;
              mem_wdata.retired = 1'b0;
              mem_wdata.op      = op_r[1:0];
              mem_wdata.comp    = comp_r;
              mem_wdata.len     = len_r;
              mem_wdata.tag     = tag_r;
              res_nxt.status    = STS_OK;
              res_nxt.idx       = 4'(chk_idx_r);
              res_nxt.gen       = new_gen;
              res_nxt.op        = op_r[1:0];
              res_nxt.comp      = comp_r;
              res_nxt.len       = len_r;
              res_nxt.tag       = tag_r;
            end
            state_nxt = ST_DONE;
          end else if (mem_rdata.retired) begin
            res_nxt.status = STS_NOT_FOUND;
            state_nxt      = ST_DONE;
          end else if (mem_rdata.gen != gen_r) begin
            res_nxt.status = STS_MISMATCH;
            state_nxt      = ST_DONE;
          end else begin
            res_nxt.status = STS_OK;
            res_nxt.idx    = 4'(chk_idx_r);
            res_nxt.gen    = mem_rdata.gen;
            res_nxt.op     = mem_rdata.op;
            res_nxt.comp   = mem_rdata.comp;
            res_nxt.len    = mem_rdata.len;
            res_nxt.tag    = mem_rdata.tag;
            if (cmd_r == CMD_RETIRE) begin
              scan_nxt  = '0;
              state_nxt = ST_SWEEP;
            end else begin
              state_nxt = ST_DONE;
            end
          end
        end else if (!chk_v_r && scan_r >= used_r) begin
          // no slot holds the key
          if (cmd_r == CMD_RECORD) begin
            if (used_r == CNT_FULL) begin
              res_nxt.status = STS_FULL;
            end else begin
              mem_we            = 1'b1;
              mem_waddr         = used_r[IDX_W-1:0];
              mem_wdata.key     = key_r;
              mem_wdata.gen     = 16'd1;
              mem_wdata.retired = 1'b0;
              mem_wdata.op      = op_r[1:0];
              mem_wdata.comp    = comp_r;
              mem_wdata.len     = len_r;
              mem_wdata.tag     = tag_r;
              used_nxt          = used_r + CNT_W'(1);
              res_nxt.status    = STS_OK;
              res_nxt.idx       = 4'(used_r[IDX_W-1:0]);
              res_nxt.gen       = 16'd1;
              res_nxt.op        = op_r[1:0];
              res_nxt.comp      = comp_r;
              res_nxt.len       = len_r;
              res_nxt.tag       = tag_r;
            end
          end else begin
            res_nxt.status = STS_NOT_FOUND;
          end
          state_nxt = ST_DONE;
        end else begin
          // advance the scan
          issue = (scan_r < used_r);
          if (issue) begin
            scan_nxt = scan_r + CNT_W'(1);
          end
        end
      end

      ST_SWEEP: begin
        // write back the slot read last cycle while reading the next
        if (sweep_hit) begin
          mem_we            = 1'b1;
          mem_waddr         = chk_idx_r;
          mem_wdata         = mem_rdata;
          mem_wdata.retired = 1'b1;
        end
        if (!chk_v_r && scan_r >= used_r) begin
          state_nxt = ST_DONE;
        end else begin
          issue = (scan_r < used_r);
          if (issue) begin
            scan_nxt = scan_r + CNT_W'(1);
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    chk_v_nxt = issue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      scan_r      <= '0;
      chk_v_r     <= 1'b0;
      qp_live_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      scan_r      <= scan_nxt;
      chk_v_r     <= chk_v_nxt;
      qp_live_r   <= qp_live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    gen_r     <= gen_nxt;
    op_r      <= op_nxt;
    comp_r    <= comp_nxt;
    len_r     <= len_nxt;
    tag_r     <= tag_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
  end

  // fill count never passes the table size
  assert property (@(posedge clk) disable iff (!rst_n) used_r <= CNT_FULL)
    else $error("slot fill count beyond table size");

  // the memory is written only by a search decision or the sweep
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_SEARCH || state_r == ST_SWEEP))
    else $error("slot memory written outside search or sweep");

  // the fill count only steps up by one
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && used_r != $past(used_r)) |-> used_r == $past(used_r) + CNT_W'(1))
    else $error("slot fill count moved by other than one");

  // a new result enters the output register only from the finish state
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside finish state");

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import sst_pkg::*;

  // Command and operation codes that the package leaves unnamed
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [2:0] OP_MESSAGE = 3'd0;
  localparam logic [2:0] OP_PUT     = 3'd1;
  localparam logic [2:0] OP_GET     = 3'd2;
  localparam logic [2:0] OP_FLUSH   = 3'd3;
  localparam logic [2:0] OP_TOP     = 3'd7;

  // Worst case per item is a retire over a full table plus gaps and stalls on
  // each side; about 1100 items in all.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int REUSE_ROUNDS = 40;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] key;
    logic [15:0] gen;
    logic [2:0]  op;
    logic        comp;
    logic [31:0] len;
    logic [15:0] tag;
  } send_req_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // [15:0] work counter, [31:16] generation, [34:32] op kind,
  // [35] completion flag, [67:36] byte length, [83:68] request tag
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  // [1:0] cmd
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [3:0] slot_index, [19:4] slot_generation, [21:20] slot_op,
  // [22] slot_completion, [54:23] slot_length, [70:55] slot_tag
  logic [OUT_TDATA_W-1:0] out_tdata;
  // [2:0] status
  logic [2:0]             out_tuser;
  logic                   cfg_wr_en = 1'b0;
  logic                   cfg_wr_data = 1'b0;

  // Shadow copy of the slot table, as the block should hold it
  slot_t   shadow_slot [SST_MAX_SLOTS];
  int      shadow_fill = 0;
  bit      shadow_live = 1'b1;

  result_t pending_results [$];
  result_t front_result;
  bit      idle_on = 1'b0;
  int      fail_count = 0;
  int      items_sent = 0;
  int      reuse_items = 0;
  int      results_checked = 0;
  int      status_seen [8];
  int      cycle_count = 0;

  send_slot_shadow_tracker uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Apply one accepted command to the shadow table and return its result.
  function automatic result_t apply_to_shadow(send_req_t r);
    result_t     res;
    int          hit;
    logic [15:0] next_gen;
    logic [15:0] key_gap;
    res = '0;
    hit = -1;
    // find the first used slot holding the key
    for (int i = 0; i < shadow_fill; i++) begin
      if (hit < 0 && shadow_slot[i].key == r.key) hit = i;
    end
    if (r.cmd == CMD_RECORD) begin
      if (!shadow_live || r.op >= OP_LIMIT) begin
        res.status = STS_INVALID;
      end else if (hit >= 0 && !shadow_slot[hit].retired) begin
        res.status = STS_EXISTS;
      end else if (hit < 0 && shadow_fill >= SST_MAX_SLOTS) begin
        res.status = STS_FULL;
      end else begin
        if (hit >= 0) begin
          // reuse a retired slot: bump the generation, never land on zero
          next_gen = shadow_slot[hit].gen + 16'd1;
          if (next_gen == 16'd0) next_gen = 16'd1;
        end else begin
          hit = shadow_fill;
          shadow_fill++;
          next_gen = 16'd1;
        end
        shadow_slot[hit].key = r.key;
        shadow_slot[hit].gen = next_gen;
        shadow_slot[hit].retired = 1'b0;
        shadow_slot[hit].op = r.op[1:0];
        shadow_slot[hit].comp = r.comp;
        shadow_slot[hit].len = r.len;
        shadow_slot[hit].tag = r.tag;
      end
    end else if (r.cmd == CMD_VALIDATE || r.cmd == CMD_RETIRE) begin
      if (hit < 0 || shadow_slot[hit].retired) begin
        res.status = STS_NOT_FOUND;
      end else if (shadow_slot[hit].gen != r.gen) begin
        res.status = STS_MISMATCH;
      end else if (r.cmd == CMD_RETIRE) begin
        // sweep: retire live slots of this generation circularly at or before the key
        for (int i = 0; i < shadow_fill; i++) begin
          key_gap = shadow_slot[i].key - r.key;
          if (!shadow_slot[i].retired && shadow_slot[i].gen == r.gen &&
              (key_gap == 16'd0 || key_gap[15])) begin
            shadow_slot[i].retired = 1'b1;
          end
        end
      end
    end else begin
      res.status = STS_INVALID;
    end
    // a failed command leaves every slot field at zero
    if (res.status == STS_OK) begin
      res.idx = hit[3:0];
      res.gen = shadow_slot[hit].gen;
      res.op = shadow_slot[hit].op;
      res.comp = shadow_slot[hit].comp;
      res.len = shadow_slot[hit].len;
      res.tag = shadow_slot[hit].tag;
    end
    return res;
  endfunction

  function automatic send_req_t make_req(logic [1:0] cmd, logic [15:0] key,
                                         logic [15:0] gen, logic [2:0] op,
                                         logic comp, logic [31:0] len,
                                         logic [15:0] tag);
    send_req_t r;
    r.cmd = cmd;
    r.key = key;
    r.gen = gen;
    r.op = op;
    r.comp = comp;
    r.len = len;
    r.tag = tag;
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Drive one item and hold it until the block takes it. Valid stays high on
  // return so that a back-to-back item can follow in the same step.
  task automatic post_item(input send_req_t r);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.cmd;
    in_tdata <= {4'b0, r.tag, r.len, r.comp, r.op, r.gen, r.key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_to_shadow(r));
    items_sent++;
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the live flag only while the block is idle.
  task automatic set_qp_live(input bit live);
    drain_results();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= live;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_live = live;
  endtask

  // Retire and record slot 0 again and again, bumping its generation each round.
  task automatic test_slot_reuse();
    send_req_t r;
    idle_on = 1'b0;
    r = make_req(CMD_RECORD, 16'h1234, 16'h0000, OP_PUT, 1'b0, 32'h0000_5a5a, 16'h0001);
    post_item(r);
    for (int n = 0; n < REUSE_ROUNDS; n++) begin
      r.cmd = CMD_RETIRE;
      r.gen = shadow_slot[0].gen;
      post_item(r);
      r.cmd = CMD_RECORD;
      r.comp = n[0];
      r.len = $urandom;
      r.tag = n[15:0];
      post_item(r);
    end
    reuse_items = items_sent;
  endtask

  // Field extremes, every command, refusals and the circular sweep.
  task automatic test_directed_commands();
    idle_on = 1'b1;
    post_item(make_req(CMD_UNKNOWN, 16'hFFFF, 16'hFFFF, OP_TOP, 1'b1, '1, '1));
    post_item(make_req(CMD_RECORD, 16'hFFFF, 16'h0000, OP_TOP, 1'b1, '1, '1));
    post_item(make_req(CMD_RECORD, 16'hFFFF, 16'h0000, OP_FLUSH, 1'b1, '1, '1));
    post_item(make_req(CMD_RECORD, 16'hFFFF, 16'h0000, OP_MESSAGE, 1'b0, '0, '0));
    post_item(make_req(CMD_VALIDATE, 16'hFFFF, 16'h0001, OP_MESSAGE, 1'b0, '0, '0));
    post_item(make_req(CMD_VALIDATE, 16'hFFFF, 16'h0002, OP_MESSAGE, 1'b0, '0, '0));
    post_item(make_req(CMD_VALIDATE, 16'h0000, 16'h0001, OP_MESSAGE, 1'b0, '0, '0));
    // keys on both sides of the half-circle boundary around counter 0
    post_item(make_req(CMD_RECORD, 16'h0000, 16'h0000, OP_MESSAGE, 1'b0, '0, '0));
    post_item(make_req(CMD_RECORD, 16'h7FFF, 16'h0000, OP_PUT, 1'b1, 32'h8000_0000, 16'h8000));
    post_item(make_req(CMD_RECORD, 16'h8000, 16'h0000, OP_GET, 1'b0, 32'h0000_0001, 16'h7FFF));
    post_item(make_req(CMD_RECORD, 16'h8001, 16'h0000, OP_GET, 1'b1, 32'h1234_5678, 16'h00FF));
    post_item(make_req(CMD_RETIRE, 16'h0000, 16'h0001, OP_MESSAGE, 1'b0, '0, '0));
    post_item(make_req(CMD_VALIDATE, 16'h8000, 16'h0001, OP_MESSAGE, 1'b0, '0, '0));
    post_item(make_req(CMD_VALIDATE, 16'h7FFF, 16'h0001, OP_MESSAGE, 1'b0, '0, '0));
    post_item(make_req(CMD_RETIRE, 16'hFFFF, 16'h0001, OP_MESSAGE, 1'b0, '0, '0));
    post_item(make_req(CMD_RECORD, 16'h8000, 16'h0000, OP_FLUSH, 1'b1, 32'hCAFE_0000, 16'hBEEF));
    // refuse records while the queue pair is down; lookups still work
    set_qp_live(1'b0);
    post_item(make_req(CMD_RECORD, 16'h4444, 16'h0000, OP_GET, 1'b1, 32'h10, 16'h4444));
    post_item(make_req(CMD_VALIDATE, 16'h7FFF, 16'h0001, OP_MESSAGE, 1'b0, '0, '0));
    post_item(make_req(CMD_RETIRE, 16'h7FFF, 16'hFFFF, OP_MESSAGE, 1'b0, '0, '0));
    set_qp_live(1'b1);
  endtask

  // Fill the remaining slots, then try one key more than fits.
  task automatic test_table_full();
    logic [15:0] fresh_key;
    while (shadow_fill < SST_MAX_SLOTS) begin
      fresh_key = 16'($urandom);
      post_item(make_req(CMD_RECORD, fresh_key, 16'($urandom), 3'($urandom_range(0, 3)),
                         1'($urandom), $urandom, 16'($urandom)));
    end
    post_item(make_req(CMD_RECORD, 16'h5A5A, 16'h0000, OP_PUT, 1'b1, 32'h40, 16'h5A5A));
    post_item(make_req(CMD_VALIDATE, 16'h5A5A, 16'h0001, OP_MESSAGE, 1'b0, '0, '0));
  endtask

  // Mostly well-formed traffic on the stored keys and generations, some noise.
  task automatic test_random_traffic();
    send_req_t r;
    int        slot;
    int        roll;
    int        base;
    int        j;
    for (int phase = 0; phase < 5; phase++) begin
      set_qp_live(phase % 2 == 0);
      for (int n = 0; n < ((phase % 2 == 0) ? 300 : 50); n++) begin
        // alternate stretches with and without gaps on both sides
        if (n % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
        r.comp = 1'($urandom);
        r.len = $urandom;
        r.tag = 16'($urandom);
        if ($urandom_range(0, 9) == 0) r.op = 3'($urandom_range(OP_LIMIT, OP_TOP));
        else r.op = 3'($urandom_range(OP_MESSAGE, OP_FLUSH));
        slot = $urandom_range(0, shadow_fill - 1);
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          r.cmd = CMD_UNKNOWN;
          r.key = 16'($urandom);
          r.gen = 16'($urandom);
        end else begin
          if (roll < 40) r.cmd = CMD_RECORD;
          else if (roll < 70) r.cmd = CMD_VALIDATE;
          else r.cmd = CMD_RETIRE;
          // steer most records to a retired slot so keys get reused
          if (r.cmd == CMD_RECORD && $urandom_range(0, 3) != 0) begin
            base = $urandom_range(0, shadow_fill - 1);
            for (int k = 0; k < shadow_fill; k++) begin
              j = (base + k) % shadow_fill;
              if (shadow_slot[j].retired) begin
                slot = j;
                break;
              end
            end
          end
          r.key = ($urandom_range(0, 9) < 8) ? shadow_slot[slot].key : 16'($urandom);
          r.gen = ($urandom_range(0, 9) < 8) ? shadow_slot[slot].gen : 16'($urandom);
        end
        post_item(r);
      end
    end
  endtask

  // Receiver: accept most cycles, stall in short and occasional long bursts.
  initial begin : result_sink
    int stall;
    forever begin
      @(posedge clk);
      stall = pick_gap();
      if (stall == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each delivered result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with status %0d arrived with nothing pending", out_tuser);
        fail_count++;
      end else begin
        front_result = pending_results.pop_front();
        check_field("status", front_result.status, out_tuser);
        check_field("slot_index", front_result.idx, out_tdata[3:0]);
        check_field("slot_generation", front_result.gen, out_tdata[19:4]);
        check_field("slot_op", front_result.op, out_tdata[21:20]);
        check_field("slot_completion", front_result.comp, out_tdata[22]);
        check_field("slot_length", front_result.len, out_tdata[54:23]);
        check_field("slot_tag", front_result.tag, out_tdata[70:55]);
        status_seen[front_result.status]++;
        results_checked++;
      end
    end
  end

  // Hard stop if the block hangs.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_count, pending_results.size());
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : main_sequence
    foreach (status_seen[s]) status_seen[s] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_slot_reuse();
    test_directed_commands();
    test_table_full();
    test_random_traffic();

    // wait out the last results, then watch for stray ones
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d items (%0d in the slot reuse run), %0d results checked",
             items_sent, reuse_items, results_checked);
    $display("status mix: ok %0d, invalid %0d, exists %0d, not found %0d, mismatch %0d, full %0d",
             status_seen[STS_OK], status_seen[STS_INVALID], status_seen[STS_EXISTS],
             status_seen[STS_NOT_FOUND], status_seen[STS_MISMATCH], status_seen[STS_FULL]);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
